### rtl/cmdrt_pkg.sv
// Package for the command router: payload structs, codes and sizes.
// Used by the front end, the back end and the top module; depends on nothing.
package cmdrt_pkg;

    localparam int ROUTE_ENTRIES_DEF   = 64;
    localparam int PENDING_ENTRIES_DEF = 16;
    localparam int NUM_PORTS_DEF       = 8;

    typedef enum logic [1:0] {
        REQ_REGISTER = 2'd0,
        REQ_DISPATCH = 2'd1,
        REQ_STATUS   = 2'd2,
        REQ_CLEAR    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_COMMAND = 2'd1,
        ACT_STATUS  = 2'd2
    } act_t;

    typedef enum logic [2:0] {
        RESP_OK         = 3'd0,
        RESP_INVALID    = 3'd1,
        RESP_VALIDATION = 3'd2,
        RESP_FORMAT     = 3'd3,
        RESP_EXECUTION  = 3'd4,
        RESP_BUSY       = 3'd5
    } resp_t;

    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_DISPATCHED = 4'd1,
        EV_INVALID    = 4'd2,
        EV_TOOMANY    = 4'd3,
        EV_MALFORMED  = 4'd4,
        EV_OK         = 4'd5,
        EV_FAILED     = 4'd6,
        EV_REGISTERED = 4'd7,
        EV_FULL       = 4'd8,
        EV_DUPLICATE  = 4'd9,
        EV_MISMATCH   = 4'd10,
        EV_CLEARED    = 4'd11
    } ev_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RT_RD,
        ST_RT_CMP,
        ST_RT_END,
        ST_FREE,
        ST_PD_RD,
        ST_PD_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  port;
        logic [31:0] opcode;
        logic [31:0] context_req;
        logic [31:0] seq_in;
        logic [2:0]  response_in;
        logic        malformed;
    } in_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  out_port;
        logic [31:0] out_opcode;
        logic [31:0] out_value;
        logic [2:0]  out_response;
        logic [3:0]  event_res;
    } out_t;

    // Classified request handed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [2:0]  port;
        logic [31:0] opcode;
        logic [31:0] context_req;
        logic [31:0] seq_in;
        logic [2:0]  response_in;
        logic        malformed;
    } job_t;

    typedef struct packed {
        logic [31:0] opcode;
        logic [2:0]  port;
    } route_t;

    typedef struct packed {
        logic [31:0] opcode;
        logic [31:0] seq;
        logic [31:0] context_val;
        logic [2:0]  caller;
    } pend_t;

    function automatic out_t mk_res(logic [1:0] act, logic [2:0] prt, logic [31:0] opc,
                                    logic [31:0] val, logic [2:0] resp, logic [3:0] ev);
        out_t r;
        r.action       = act;
        r.out_port     = prt;
        r.out_opcode   = opc;
        r.out_value    = val;
        r.out_response = resp;
        r.event_res    = ev;
        return r;
    endfunction

endpackage

### rtl/cmdrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module cmdrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/cmdrt_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on cmdrt_pkg.
module cmdrt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  cmdrt_pkg::in_t  cmd,
    output logic            job_valid,
    input  logic            job_take,
    output cmdrt_pkg::job_t job
);
    import cmdrt_pkg::*;

    job_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    job_t       cls;
    logic       push, pop;

    // Classify the incoming request
    always_comb
    begin
        cls.port        = cmd.port;
        cls.opcode      = cmd.opcode;
        cls.context_req = cmd.context_req;
        cls.seq_in      = cmd.seq_in;
        cls.response_in = cmd.response_in;
        cls.malformed   = cmd.malformed;
        unique case (cmd.req_type)
            2'd0:    cls.kind = REQ_REGISTER;
            2'd1:    cls.kind = REQ_DISPATCH;
            2'd2:    cls.kind = REQ_STATUS;
            default: cls.kind = REQ_CLEAR;
        endcase
    end

    assign cmd_stall = (cnt_reg == 2'd2);
    assign push      = cmd_valid && !cmd_stall;
    assign pop       = job_take && job_valid;
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end
endmodule

### rtl/cmdrt_back.sv
// Back end: takes one request at a time, scans the route table and the tracker
// entry by entry and builds the result. Depends on cmdrt_pkg and cmdrt_ram.
module cmdrt_back #(
    parameter int ROUTE_ENTRIES   = cmdrt_pkg::ROUTE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = cmdrt_pkg::PENDING_ENTRIES_DEF,
    parameter int NUM_PORTS       = cmdrt_pkg::NUM_PORTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_take,
    input  cmdrt_pkg::job_t job,
    input  logic [7:0]      target_mask,
    input  logic [7:0]      caller_mask,
    output logic            res_valid,
    input  logic            res_stall,
    output cmdrt_pkg::out_t res
);
    import cmdrt_pkg::*;

    localparam int RAW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int RCW = $clog2(ROUTE_ENTRIES + 1);
    localparam int PAW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int PCW = $clog2(PENDING_ENTRIES + 1);

    state_t               state_reg, state_next;
    job_t                 job_reg, job_next;
    logic [RCW-1:0]       ridx_reg, ridx_next;
    logic [RCW-1:0]       fill_reg, fill_next;
    logic [PCW-1:0]       pidx_reg, pidx_next;
    logic [31:0]          seq_reg, seq_next;
    logic [PENDING_ENTRIES-1:0] pvalid_reg, pvalid_next;
    logic                 hit_reg, hit_next;
    logic [2:0]           hport_reg, hport_next;
    out_t                 fin_reg, fin_next;
    out_t                 res_reg, res_next;
    logic                 res_valid_reg, res_valid_next;

    logic                 rt_we;
    route_t               rt_wdata, rt_rdata;
    logic                 pd_we;
    pend_t                pd_wdata, pd_rdata;

    logic rt_end, rt_match, rt_full, pd_end, pd_hit, out_free;
    logic caller_ok, target_ok, pend_caller_ok;
    logic [3:0] st_ev;

    function automatic logic linked(logic [7:0] mask, logic [2:0] p);
        return (32'(p) < NUM_PORTS) && mask[p];
    endfunction

    cmdrt_ram #(.WIDTH($bits(route_t)), .DEPTH(ROUTE_ENTRIES)) u_route (
        .clk   (clk),
        .we    (rt_we),
        .waddr (fill_reg[RAW-1:0]),
        .wdata (rt_wdata),
        .raddr (ridx_reg[RAW-1:0]),
        .rdata (rt_rdata)
    );

    cmdrt_ram #(.WIDTH($bits(pend_t)), .DEPTH(PENDING_ENTRIES)) u_pend (
        .clk   (clk),
        .we    (pd_we),
        .waddr (pidx_reg[PAW-1:0]),
        .wdata (pd_wdata),
        .raddr (pidx_reg[PAW-1:0]),
        .rdata (pd_rdata)
    );

    // Scan conditions
    assign rt_end         = (ridx_reg == fill_reg);
    assign rt_match       = (rt_rdata.opcode == job_reg.opcode);
    assign rt_full        = (fill_reg == RCW'(ROUTE_ENTRIES));
    assign pd_end         = (pidx_reg == PCW'(PENDING_ENTRIES));
    assign pd_hit         = (pd_rdata.seq == job_reg.seq_in);
    assign out_free       = !res_valid_reg || !res_stall;
    assign caller_ok      = linked(caller_mask, job_reg.port);
    assign target_ok      = hit_reg && linked(target_mask, hport_reg);
    assign pend_caller_ok = linked(caller_mask, pd_rdata.caller);
    assign st_ev          = (job_reg.response_in == RESP_OK) ? EV_OK : EV_FAILED;
    assign job_take       = (state_reg == ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    unique case (job.kind)
                        REQ_REGISTER: state_next = ST_RT_RD;
                        REQ_DISPATCH: state_next = job.malformed ? ST_DONE : ST_RT_RD;
                        REQ_STATUS:   state_next = ST_PD_RD;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_RT_RD:
            begin
                state_next = rt_end ? ST_RT_END : ST_RT_CMP;
            end
            ST_RT_CMP:
            begin
                if (rt_match)
                begin
                    state_next = (job_reg.kind == REQ_REGISTER) ? ST_DONE : ST_RT_END;
                end
                else
                begin
                    state_next = ST_RT_RD;
                end
            end
            ST_RT_END:
            begin
                if (job_reg.kind == REQ_DISPATCH && target_ok && caller_ok)
                begin
                    state_next = ST_FREE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FREE:
            begin
                if (pd_end || !pvalid_reg[pidx_reg[PAW-1:0]])
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PD_RD:
            begin
                if (pd_end)
                begin
                    state_next = ST_DONE;
                end
                else if (pvalid_reg[pidx_reg[PAW-1:0]])
                begin
                    state_next = ST_PD_CMP;
                end
            end
            ST_PD_CMP:
            begin
                state_next = pd_hit ? ST_DONE : ST_PD_RD;
            end
            default:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Datapath and table updates
    always_comb
    begin
        job_next       = job_reg;
        ridx_next      = ridx_reg;
        fill_next      = fill_reg;
        pidx_next      = pidx_reg;
        seq_next       = seq_reg;
        pvalid_next    = pvalid_reg;
        hit_next       = hit_reg;
        hport_next     = hport_reg;
        fin_next       = fin_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        rt_we          = 1'b0;
        rt_wdata.opcode = job_reg.opcode;
        rt_wdata.port   = job_reg.port;
        pd_we          = 1'b0;
        pd_wdata.opcode      = job_reg.opcode;
        pd_wdata.seq         = seq_reg;
        pd_wdata.context_val = job_reg.context_req;
        pd_wdata.caller      = job_reg.port;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_next  = job;
                    ridx_next = '0;
                    pidx_next = '0;
                    hit_next  = 1'b0;
                    // Malformed dispatch and clear finish at once
                    if (job.kind == REQ_CLEAR)
                    begin
                        pvalid_next = '0;
                        fin_next = mk_res(ACT_NONE, 3'd0, 32'd0, 32'd0, 3'd0, EV_CLEARED);
                    end
                    else if (linked(caller_mask, job.port))
                    begin
                        fin_next = mk_res(ACT_STATUS, job.port, job.opcode, job.context_req,
                                          RESP_VALIDATION, EV_MALFORMED);
                    end
                    else
                    begin
                        fin_next = mk_res(ACT_NONE, 3'd0, 32'd0, 32'd0, 3'd0, EV_MALFORMED);
                    end
                end
            end
            ST_RT_CMP:
            begin
                if (rt_match)
                begin
                    hit_next   = 1'b1;
                    hport_next = rt_rdata.port;
                    fin_next   = mk_res(ACT_NONE, 3'd0, 32'd0, 32'd0, 3'd0,
                                        (rt_rdata.port == job_reg.port) ? EV_REGISTERED
                                                                        : EV_DUPLICATE);
                end
                else
                begin
                    ridx_next = ridx_reg + RCW'(1);
                end
            end
            ST_RT_END:
            begin
                if (job_reg.kind == REQ_REGISTER)
                begin
                    if (rt_full)
                    begin
                        fin_next = mk_res(ACT_NONE, 3'd0, 32'd0, 32'd0, 3'd0, EV_FULL);
                    end
                    else
                    begin
                        rt_we     = 1'b1;
                        fill_next = fill_reg + RCW'(1);
                        fin_next  = mk_res(ACT_NONE, 3'd0, 32'd0, 32'd0, 3'd0, EV_REGISTERED);
                    end
                end
                else if (target_ok)
                begin
                    fin_next = mk_res(ACT_COMMAND, hport_reg, job_reg.opcode, seq_reg, 3'd0,
                                      EV_DISPATCHED);
                    if (!caller_ok)
                    begin
                        seq_next = seq_reg + 32'd1;
                    end
                end
                else
                begin
                    seq_next = seq_reg + 32'd1;
                    if (caller_ok)
                    begin
                        fin_next = mk_res(ACT_STATUS, job_reg.port, job_reg.opcode,
                                          job_reg.context_req, RESP_INVALID, EV_INVALID);
                    end
                    else
                    begin
                        fin_next = mk_res(ACT_NONE, 3'd0, 32'd0, 32'd0, 3'd0, EV_INVALID);
                    end
                end
            end
            ST_FREE:
            begin
                if (pd_end)
                begin
                    fin_next = mk_res(ACT_STATUS, job_reg.port, job_reg.opcode,
                                      job_reg.context_req, RESP_EXECUTION, EV_TOOMANY);
                end
                else if (!pvalid_reg[pidx_reg[PAW-1:0]])
                begin
                    pd_we = 1'b1;
                    pvalid_next[pidx_reg[PAW-1:0]] = 1'b1;
                    seq_next = seq_reg + 32'd1;
                end
                else
                begin
                    pidx_next = pidx_reg + PCW'(1);
                end
            end
            ST_PD_RD:
            begin
                if (pd_end)
                begin
                    fin_next = mk_res(ACT_NONE, 3'd0, 32'd0, 32'd0, 3'd0, st_ev);
                end
                else if (!pvalid_reg[pidx_reg[PAW-1:0]])
                begin
                    pidx_next = pidx_reg + PCW'(1);
                end
            end
            ST_PD_CMP:
            begin
                if (!pd_hit)
                begin
                    pidx_next = pidx_reg + PCW'(1);
                end
                else if (pd_rdata.opcode != job_reg.opcode)
                begin
                    fin_next = mk_res(ACT_NONE, 3'd0, 32'd0, 32'd0, 3'd0, EV_MISMATCH);
                end
                else
                begin
                    pvalid_next[pidx_reg[PAW-1:0]] = 1'b0;
                    if (pend_caller_ok)
                    begin
                        fin_next = mk_res(ACT_STATUS, pd_rdata.caller, job_reg.opcode,
                                          pd_rdata.context_val, job_reg.response_in, st_ev);
                    end
                    else
                    begin
                        fin_next = mk_res(ACT_NONE, 3'd0, 32'd0, 32'd0, 3'd0, st_ev);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_next       = fin_reg;
                    res_valid_next = 1'b1;
                end
            end
            default:
            begin
                ridx_next = ridx_reg;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            seq_reg       <= 32'd0;
            pvalid_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            seq_reg       <= seq_next;
            pvalid_reg    <= pvalid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold request and scan payload
    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        ridx_reg  <= ridx_next;
        pidx_reg  <= pidx_next;
        hit_reg   <= hit_next;
        hport_reg <= hport_next;
        fin_reg   <= fin_next;
        res_reg   <= res_next;
    end
endmodule

### rtl/command_router_with_tracker.sv
// Command router with pending tracker. One request in flight in the back end;
// the time a register, dispatch or status request takes is set by the
// entry-by-entry scan of the route RAM and the tracker RAM, while clear and
// malformed dispatch skip the scans.
// A two-entry request queue keeps accepting, until it is full, while a result waits.
// Reset (rst_n low, asynchronous) empties routes, tracker, sequence and masks.
module command_router_with_tracker #(
    parameter int ROUTE_ENTRIES   = cmdrt_pkg::ROUTE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = cmdrt_pkg::PENDING_ENTRIES_DEF,
    parameter int NUM_PORTS       = cmdrt_pkg::NUM_PORTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  cmdrt_pkg::in_t  cmd,
    output logic            res_valid,
    input  logic            res_stall,
    output cmdrt_pkg::out_t res,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import cmdrt_pkg::*;

    logic [7:0] target_mask_reg;
    logic [7:0] caller_mask_reg;
    logic       job_valid, job_take;
    job_t       job;
    logic       cfg_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {24'd0, caller_mask_reg} : {24'd0, target_mask_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_mask_reg <= 8'd0;
            caller_mask_reg <= 8'd0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                caller_mask_reg <= pwdata[7:0];
            end
            else
            begin
                target_mask_reg <= pwdata[7:0];
            end
        end
    end

    cmdrt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    cmdrt_back #(
        .ROUTE_ENTRIES   (ROUTE_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES),
        .NUM_PORTS       (NUM_PORTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_take    (job_take),
        .job         (job),
        .target_mask (target_mask_reg),
        .caller_mask (caller_mask_reg),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res)
    );
endmodule
